/* hdl/lifo_stack_with_search_top_assert.svh */
// Assertion macros for the LIFO stack with search.
// Expects clk and arst_n in the scope of each use.
`ifndef LIFO_STACK_WITH_SEARCH_TOP_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_TOP_ASSERT_SVH

// same-cycle implication
`define LSS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lss_pkg.sv */
// Shared constants, codes and types of the LIFO stack with search.
// No dependencies.
`default_nettype none
package lss_pkg;
	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int GRP = 8;
	localparam int NGRP = (DEPTH + GRP - 1) / GRP;
	localparam int LOC_W = $clog2(GRP);

	localparam int OP_W = 3;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int FIDX_W = 6;
	localparam int CAP_W = 7;
	localparam int COUNT_W = 7;

	localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OP_W-1:0] OP_POP = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_GRP,
		ST_FIN
	} lss_state_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic cmp;
	} lss_cell_ctrl_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic signed [WORD_W-1:0] data;
		logic [FIDX_W-1:0] found_index;
		logic [COUNT_W-1:0] count;
		logic empty_res;
		logic full_res;
	} lss_res_t;
endpackage
`default_nettype wire

/* hdl/lss_req_if.sv */
// Request channel of the stack: valid/ready with op and value.
// Depends on lss_pkg.
`default_nettype none
interface lss_req_if
	import lss_pkg::*;
;
	logic valid;
	logic ready;
	logic [OP_W-1:0] op;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface
`default_nettype wire

/* hdl/lss_res_if.sv */
// Result channel of the stack: valid/ready with status, data and counts.
// Depends on lss_pkg.
`default_nettype none
interface lss_res_if
	import lss_pkg::*;
;
	logic valid;
	logic ready;
	logic [STAT_W-1:0] status;
	logic signed [WORD_W-1:0] data;
	logic [FIDX_W-1:0] found_index;
	logic [COUNT_W-1:0] count;
	logic empty_res;
	logic full_res;

	modport source (output valid, output status, output data, output found_index,
		output count, output empty_res, output full_res, input ready);
	modport sink (input valid, input status, input data, input found_index,
		input count, input empty_res, input full_res, output ready);
endinterface
`default_nettype wire

/* hdl/lifo_stack_with_search_top.sv */
// Top level of the LIFO stack with search: control, fill count, cell chain.
// Depends on lss_pkg, lss_req_if, lss_res_if, lss_cell, lss_prio and the macros.
//
// Usage:
//  - req carries op and value; res returns one word per request: status,
//    data, found_index, count, empty_res, full_res. cfg_we/cfg_wdata write
//    capacity; the user must do so only while the block is idle, as the block does not enforce it.
//  - The stack is a chain of cells with the top word in cell 0; push and
//    pop shift every cell of the chain at the same clock edge.
//  - Push, pop, peek, clear and unused codes: result is registered at the
//    edge that takes the request and is valid in the next cycle; one request
//    per cycle while res keeps up.
//  - Search: every cell compares its word with the key, then a two-level
//    priority encoder finds the topmost match. The request passes CMP (match
//    flags registered), GRP (group level registered) and FIN (result loaded
//    once res is free); the next request can be taken as the result turns valid.
//  - Reset empties the stack and sets capacity to 64; stored words are
//    left as they are and never read until pushed again.
//  - When res stalls, the finished result holds in its output register and
//    req.ready stays low until it is taken or is being taken.
`default_nettype none
`include "lifo_stack_with_search_top_assert.svh"
module lifo_stack_with_search_top
	import lss_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	lss_req_if.sink               req,
	lss_res_if.source             res,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata
);
	lss_state_t state_q, state_d;
	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] fill_q, fill_d, eff_cap;
	logic signed [WORD_W-1:0] key_q;
	logic res_valid_q, res_load, slot_free, accept;
	lss_res_t res_q, res_d;
	lss_cell_ctrl_t ctrl;
	logic signed [WORD_W-1:0] word [DEPTH];
	logic [DEPTH-1:0] match;
	logic hit;
	logic [IDX_W-1:0] top_idx;
	logic [CNT_W-1:0] bot_idx;

	assign eff_cap = (int'(capacity_q) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(capacity_q);
	assign slot_free = !res_valid_q || res.ready;
	assign accept = req.valid && req.ready;
	assign bot_idx = fill_q - CNT_W'(1) - CNT_W'(top_idx);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WORD_W-1:0] above, below;
		if (i == 0) begin : g_top
			assign above = req.value;
		end else begin : g_mid
			assign above = word[i-1];
		end
		if (i == DEPTH - 1) begin : g_bot
			assign below = word[i];
		end else begin : g_rest
			assign below = word[i+1];
		end
		lss_cell u_cell (
			.clk    (clk),
			.ctrl   (ctrl),
			.above  (above),
			.below  (below),
			.key    (key_q),
			.active (CNT_W'(i) < fill_q),
			.word_q (word[i]),
			.match_q(match[i])
		);
	end

	lss_prio u_prio (
		.clk  (clk),
		.en   (state_q == ST_GRP),
		.match(match),
		.hit  (hit),
		.idx  (top_idx)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req.op == OP_SEARCH) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: state_d = ST_GRP;
			ST_GRP: state_d = ST_FIN;
			ST_FIN: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		ctrl = '0;
		fill_d = fill_q;
		res_load = 1'b0;
		res_d = '0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = slot_free;
				if (accept) begin
					res_load = (req.op != OP_SEARCH);
					case (req.op)
						OP_PUSH: begin
							if (fill_q >= eff_cap) begin
								res_d.status = STAT_FULL;
							end else begin
								ctrl.push = 1'b1;
								fill_d = fill_q + CNT_W'(1);
							end
						end
						OP_POP: begin
							if (fill_q == '0) begin
								res_d.status = STAT_EMPTY;
							end else begin
								ctrl.pop = 1'b1;
								fill_d = fill_q - CNT_W'(1);
								res_d.data = word[0];
							end
						end
						OP_PEEK: begin
							if (fill_q == '0) begin
								res_d.status = STAT_EMPTY;
							end else begin
								res_d.data = word[0];
							end
						end
						OP_CLEAR: fill_d = '0;
						default: ;
					endcase
				end
			end
			ST_CMP: ctrl.cmp = 1'b1;
			ST_GRP: ;
			ST_FIN: begin
				res_load = slot_free;
				if (hit) begin
					res_d.found_index = FIDX_W'(bot_idx);
				end else begin
					res_d.status = STAT_NOTFOUND;
				end
			end
			default: ;
		endcase
		res_d.count = COUNT_W'(fill_d);
		res_d.empty_res = (fill_d == '0);
		res_d.full_res = (fill_d >= eff_cap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			capacity_q <= CAP_RESET;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
		if (accept && req.op == OP_SEARCH) begin
			key_q <= req.value;
		end
	end

	assign res.valid = res_valid_q;
	assign res.status = res_q.status;
	assign res.data = res_q.data;
	assign res.found_index = res_q.found_index;
	assign res.count = res_q.count;
	assign res.empty_res = res_q.empty_res;
	assign res.full_res = res_q.full_res;

	`LSS_ASSERT_NEXT(a_push_grows, accept && req.op == OP_PUSH && fill_q < eff_cap,
		fill_q == $past(fill_q) + CNT_W'(1), "push did not grow the stack")
	`LSS_ASSERT_NEXT(a_fill_held, state_q != ST_IDLE, $stable(fill_q),
		"fill count moved during a search")
	`LSS_ASSERT_SAME(a_search_seq, accept && req.op == OP_SEARCH, ##2 state_q == ST_GRP,
		"search did not reach the encode step")
	`LSS_ASSERT_SAME(a_hit_in_range, state_q == ST_FIN && hit, CNT_W'(top_idx) < fill_q,
		"match beyond the stored words")
endmodule
`default_nettype wire

/* hdl/lss_cell.sv */
// One stack cell: holds a word, shifts with its neighbors, compares to the key.
// Depends on lss_pkg.
`default_nettype none
module lss_cell
	import lss_pkg::*;
(
	input  wire logic                     clk,
	input  wire lss_cell_ctrl_t           ctrl,
	input  wire logic signed [WORD_W-1:0] above,
	input  wire logic signed [WORD_W-1:0] below,
	input  wire logic signed [WORD_W-1:0] key,
	input  wire logic                     active,
	output logic signed [WORD_W-1:0]      word_q,
	output logic                          match_q
);
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			word_q <= above;
		end else if (ctrl.pop) begin
			word_q <= below;
		end
		if (ctrl.cmp) begin
			match_q <= active && (word_q == key);
		end
	end
endmodule
`default_nettype wire

/* hdl/lss_prio.sv */
// Two-level priority encoder over the cell match flags; the lowest-numbered cell wins.
// Group level is registered, final level is combinational. Depends on lss_pkg.
`default_nettype none
module lss_prio
	import lss_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [DEPTH-1:0] match,
	output logic                  hit,
	output logic [IDX_W-1:0]      idx
);
	logic [NGRP-1:0]            grp_hit_q;
	logic [NGRP-1:0][LOC_W-1:0] grp_loc_q;
	logic [NGRP-1:0]            grp_hit_d;
	logic [NGRP-1:0][LOC_W-1:0] grp_loc_d;

	always_comb begin
		grp_hit_d = '0;
		grp_loc_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			for (int k = GRP - 1; k >= 0; k--) begin
				if ((g * GRP + k < DEPTH) && match[g * GRP + k]) begin
					grp_hit_d[g] = 1'b1;
					grp_loc_d[g] = LOC_W'(k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_hit_q <= grp_hit_d;
			grp_loc_q <= grp_loc_d;
		end
	end

	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_hit_q[g]) begin
				hit = 1'b1;
				idx = IDX_W'(g * GRP + int'(grp_loc_q[g]));
			end
		end
	end
endmodule
`default_nettype wire

/* bench/lss_stack_checker.sv */
// Checker for the LIFO stack with search: watches the request, result and capacity ports,
// predicts each result word and compares it with what the block returns.
// Depends on lss_pkg, lss_req_if and lss_res_if.
module lss_stack_checker
	import lss_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	lss_req_if                    req,
	lss_res_if                    res,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata,
	output int                    errors,
	output int                    outstanding
);
	logic [WORD_W-1:0] stack_words [DEPTH];
	int unsigned stack_fill = 0;
	logic [CAP_W-1:0] capacity_reg = CAP_RESET;
	lss_res_t expected_results [$];
	lss_res_t want;
	int fail_count = 0;
	int pending_n = 0;

	assign errors = fail_count;
	assign outstanding = pending_n;

	function automatic lss_res_t stack_apply(logic [OP_W-1:0] op, logic [WORD_W-1:0] word);
		lss_res_t r;
		int unsigned limit;
		limit = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
		r = '0;
		r.status = STAT_OK;
		case (op)
			OP_PUSH: begin
				if (stack_fill >= limit) begin
					r.status = STAT_FULL;
				end else begin
					stack_words[stack_fill] = word;
					stack_fill++;
				end
			end
			OP_POP: begin
				if (stack_fill == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					stack_fill--;
					r.data = stack_words[stack_fill];
				end
			end
			OP_PEEK: begin
				if (stack_fill == 0) r.status = STAT_EMPTY;
				else r.data = stack_words[stack_fill - 1];
			end
			OP_CLEAR: begin
				stack_fill = 0;
			end
			OP_SEARCH: begin
				// bottom-up scan, last hit is the topmost match
				r.status = STAT_NOTFOUND;
				for (int i = 0; i < int'(stack_fill); i++) begin
					if (stack_words[i] == word) begin
						r.status = STAT_OK;
						r.found_index = i[FIDX_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
		r.count = stack_fill[COUNT_W-1:0];
		r.empty_res = (stack_fill == 0);
		r.full_res = (stack_fill >= limit);
		return r;
	endfunction

	task automatic check_field(string name, logic signed [63:0] exp_v, logic signed [63:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_fill = 0;
			capacity_reg = CAP_RESET;
			expected_results.delete();
			pending_n = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with no request outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, res.status);
					check_field("data", want.data, res.data);
					check_field("found_index", want.found_index, res.found_index);
					check_field("count", want.count, res.count);
					check_field("empty_res", want.empty_res, res.empty_res);
					check_field("full_res", want.full_res, res.full_res);
				end
			end
			if (req.valid && req.ready) expected_results.push_back(stack_apply(req.op, req.value));
			if (cfg_we) capacity_reg = cfg_wdata;
			pending_n = expected_results.size();
		end
	end
endmodule

/* bench/lifo_stack_with_search_top_tb.sv */
// Testbench top for the LIFO stack with search: clock, reset, request stimulus,
// result back-pressure, capacity writes and the verdict. Depends on lss_pkg,
// lss_req_if, lss_res_if, lss_stack_checker and lifo_stack_with_search_top.
module lifo_stack_with_search_top_tb;
	import lss_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 160;
	localparam int PHASE_ITEMS = 75;
	localparam int NPHASE = 10;
	localparam int POOL_N = 12;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	int errors;
	int outstanding;
	int quiet_cycles = 0;
	bit no_gaps = 0;
	bit hold_request = 0;
	logic [WORD_W-1:0] word_pool [POOL_N];
	int cap_plan [NPHASE] = '{0, 1, 127, 65, 3, 64, 16, 100, 2, 64};

	lss_req_if req_ch ();
	lss_res_if res_ch ();

	lifo_stack_with_search_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	lss_stack_checker stack_check (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.errors(errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		if ($urandom_range(0, 1) == 1) return word_pool[$urandom_range(0, POOL_N - 1)];
		return $urandom();
	endfunction

	function automatic logic [OP_W-1:0] pick_op(bit filling);
		int r;
		r = $urandom_range(0, 99);
		if (r < (filling ? 55 : 15)) return OP_PUSH;
		if (r < (filling ? 65 : 55)) return OP_POP;
		if (r < (filling ? 72 : 65)) return OP_PEEK;
		if (r < (filling ? 94 : 90)) return OP_SEARCH;
		if (r < (filling ? 97 : 95)) return OP_CLEAR;
		return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
	endfunction

	// called at a falling edge; returns at a falling edge after the word is taken
	task automatic put(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.value <= word;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		gap = gap_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			req_ch.op <= pick_op(1'b1);
			req_ch.value <= $urandom();
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		cfg_wdata <= cap;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		repeat (2) @(negedge clk);
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		int idle_left;
		hold_left = 0;
		idle_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				idle_left = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int run;
		bit filling;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_PUSH;
		req_ch.value = '0;
		word_pool[0] = 32'h8000_0000;
		word_pool[1] = 32'h7fff_ffff;
		word_pool[2] = 32'h0000_0000;
		word_pool[3] = 32'hffff_ffff;
		word_pool[4] = 32'h0000_0001;
		for (int i = 5; i < POOL_N; i++) word_pool[i] = $urandom();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty-stack refusals, spare codes, extremes, topmost match
		put(OP_POP, 32'h0);
		put(OP_PEEK, 32'h0);
		put(OP_SEARCH, 32'h0);
		put(OP_SPARE_LO, 32'h1234_5678);
		put(OP_SPARE_HI, 32'hffff_ffff);
		put(OP_PUSH, 32'h8000_0000);
		put(OP_PUSH, 32'h7fff_ffff);
		put(OP_PUSH, 32'h0000_0000);
		put(OP_PUSH, 32'hffff_ffff);
		put(OP_PUSH, 32'h7fff_ffff);
		put(OP_PEEK, 32'h0);
		put(OP_SEARCH, 32'h8000_0000);
		put(OP_SEARCH, 32'h7fff_ffff);
		put(OP_SEARCH, 32'h0000_3039);
		put(OP_SEARCH, 32'hffff_ffff);
		put(OP_SPARE_LO + 3'd1, 32'h0);
		put(OP_POP, 32'h0);
		put(OP_POP, 32'h0);
		put(OP_CLEAR, 32'h0);
		put(OP_POP, 32'h0);
		put(OP_SEARCH, 32'h8000_0000);
		put(OP_PUSH, 32'h5555_aaaa);
		put(OP_PEEK, 32'h0);
		settle();

		for (int p = 0; p < NPHASE; p++) begin
			write_capacity(CAP_W'(cap_plan[p]));
			no_gaps = ($urandom_range(0, 3) == 0);
			if (p == 5) begin
				no_gaps = 1;
				hold_request = 1;
			end
			n = 0;
			filling = 1;
			while (n < PHASE_ITEMS) begin
				if ($urandom_range(0, 15) == 0) filling = !filling;
				if ($urandom_range(0, 19) == 0) begin
					run = ((cap_plan[p] > DEPTH) ? DEPTH : cap_plan[p]) + 2;
					for (int k = 0; k < run; k++) put(OP_PUSH, pick_word());
					n += run;
				end else begin
					put(pick_op(filling), pick_word());
					n++;
				end
			end
			settle();
		end

		repeat (20) @(negedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (outstanding != 0) $error("%0d result words never arrived", outstanding);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

/* sim.f */
+incdir+hdl
hdl/lss_pkg.sv
hdl/lss_req_if.sv
hdl/lss_res_if.sv
hdl/lss_cell.sv
hdl/lss_prio.sv
hdl/lifo_stack_with_search_top.sv
bench/lss_stack_checker.sv
bench/lifo_stack_with_search_top_tb.sv
